@@ hdl/pid_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_pkg
// Shared word types, register indexes and unit widths for the PID step block.
// ----------------------------------------------------------------------------
package pid_pkg;

    // input word
    typedef struct packed {
        logic signed [31:0] setpoint;
        logic signed [31:0] measurement;
        logic        [31:0] time_delta;
        logic               restart;
    } t_pid_in;

    // result word
    typedef struct packed {
        logic signed [16:0] drive;
        logic               saturated;
    } t_pid_out;

    // configuration register indexes
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 24;
    localparam logic [CFG_IW-1:0] CFG_KP    = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_KI    = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_KD    = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_LOWER = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_UPPER = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_OFFS  = 3'd5;
    localparam logic [CFG_IW-1:0] CFG_TRAP  = 3'd6;

    // serial multiplier: magnitude A times magnitude B
    localparam int MUL_AW = 33;
    localparam int MUL_BW = 32;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    // serial divider: (N << DIV_FW) / D, quotient held at 2^(DIV_QW-1)
    localparam int DIV_NW = 57;
    localparam int DIV_DW = 32;
    localparam int DIV_FW = 16;
    localparam int DIV_QW = 61;

endpackage

@@ hdl/pid_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_mul
// Unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module pid_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [pid_pkg::MUL_AW-1:0]  i_a,
    input  logic [pid_pkg::MUL_BW-1:0]  i_b,
    output logic                        o_done,
    output logic [pid_pkg::MUL_PW-1:0]  o_prod
);
    import pid_pkg::*;

    localparam int CW = $clog2(MUL_BW);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [MUL_AW-1:0] r_a;
    logic [MUL_PW-1:0] r_p;
    logic [MUL_AW:0]   w_add;
    logic [MUL_PW-1:0] n_p;

    // add the multiplicand into the upper half when the low bit is set
    always_comb begin
        w_add = {1'b0, r_p[MUL_PW-1:MUL_BW]} + (r_p[0] ? {1'b0, r_a} : '0);
        n_p   = {w_add, r_p[MUL_BW-1:1]};
    end

    // sequence the bit passes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(MUL_BW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // load and shift the product register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_p <= {{MUL_AW{1'b0}}, i_b};
        end else if (r_busy) begin
            r_p <= n_p;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_p;

endmodule

@@ hdl/pid_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_div
// Restoring divider, one quotient bit per cycle, quotient held at its cap.
// ----------------------------------------------------------------------------
module pid_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [pid_pkg::DIV_NW-1:0]  i_num,
    input  logic [pid_pkg::DIV_DW-1:0]  i_den,
    output logic                        o_done,
    output logic [pid_pkg::DIV_QW-1:0]  o_quot
);
    import pid_pkg::*;

    localparam int XW = DIV_NW + DIV_FW;
    localparam int CW = $clog2(XW);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [XW-1:0]     r_x;
    logic [DIV_DW-1:0] r_den;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_QW-1:0] r_q;
    logic              r_over;
    logic [DIV_DW:0]   w_sh;
    logic [DIV_DW+1:0] w_dif;
    logic              w_qbit;

    // trial subtract of the divisor
    always_comb begin
        w_sh   = {r_rem, r_x[XW-1]};
        w_dif  = {1'b0, w_sh} - {2'b00, r_den};
        w_qbit = !w_dif[DIV_DW+1];
    end

    // sequence the bit passes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(XW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift dividend in, quotient out; remember bits past the cap
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= {i_num, {DIV_FW{1'b0}}};
            r_den  <= i_den;
            r_rem  <= '0;
            r_q    <= '0;
            r_over <= 1'b0;
        end else if (r_busy) begin
            r_x    <= {r_x[XW-2:0], 1'b0};
            r_rem  <= w_qbit ? w_dif[DIV_DW-1:0] : w_sh[DIV_DW-1:0];
            r_q    <= {r_q[DIV_QW-2:0], w_qbit};
            r_over <= r_over | r_q[DIV_QW-1];
        end
    end

    assign o_done = r_done;
    assign o_quot = (r_over || r_q[DIV_QW-1]) ? {1'b1, {(DIV_QW-1){1'b0}}}
                                              : {1'b0, r_q[DIV_QW-2:0]};

endmodule

@@ hdl/pid_step_clamped.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_step_clamped
// PID controller step with clamped integral, fixed point, bit-serial datapath.
// ----------------------------------------------------------------------------
// Each word runs four serial multiplier passes and, when time_delta is
// nonzero, a restoring divide; a new word is accepted only in the idle
// state, after the previous one has gone to the output register.
// A finished word waits in the output register while the next one is taken.
// Reset (synchronous, active low) restores register defaults, clears the
// integral, previous error and running flag, and drops output valid.
module pid_step_clamped (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  pid_pkg::t_pid_in             i_in,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output pid_pkg::t_pid_out            o_out,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [pid_pkg::CFG_IW-1:0]   i_cfg_index,
    input  logic [pid_pkg::CFG_DW-1:0]   i_cfg_data
);
    import pid_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_PREP  = 4'd1;
    localparam logic [3:0] ST_BASE  = 4'd2;
    localparam logic [3:0] ST_MIGO  = 4'd3;
    localparam logic [3:0] ST_MI    = 4'd4;
    localparam logic [3:0] ST_INT   = 4'd5;
    localparam logic [3:0] ST_MP    = 4'd6;
    localparam logic [3:0] ST_MK    = 4'd7;
    localparam logic [3:0] ST_MD    = 4'd8;
    localparam logic [3:0] ST_DV    = 4'd9;
    localparam logic [3:0] ST_FIN   = 4'd10;
    localparam logic [3:0] ST_CLP   = 4'd11;

    // configuration
    logic signed [23:0] r_kp, r_ki, r_kd;
    logic signed [15:0] r_lo, r_hi, r_off;
    logic               r_trap;

    // state and datapath
    logic [3:0]         r_state;
    t_pid_in            r_in;
    logic               r_run;
    logic signed [32:0] r_prev;
    logic signed [32:0] r_err;
    logic signed [32:0] r_old;
    logic signed [33:0] r_base;
    logic signed [33:0] r_diff;
    logic signed [33:0] r_int;
    logic               r_neg;
    logic signed [63:0] r_acc;
    logic signed [31:0] r_res;
    logic               r_ovalid;
    t_pid_out           r_out;

    // unit hookup
    logic               w_mul_start, w_mul_done;
    logic [MUL_AW-1:0]  w_mul_a;
    logic [MUL_BW-1:0]  w_mul_b;
    logic [MUL_PW-1:0]  w_prod;
    logic               w_div_start, w_div_done;
    logic [DIV_QW-1:0]  w_quot;

    logic signed [32:0] w_err;
    logic               w_first;
    logic [32:0]        w_err_neg, w_err_mag;
    logic [33:0]        w_base_neg, w_int_neg, w_diff_neg;
    logic [32:0]        w_base_mag, w_int_mag, w_diff_mag;
    logic [23:0]        w_kp_neg, w_ki_neg, w_kd_neg;
    logic [23:0]        w_kp_mag, w_ki_mag, w_kd_mag;
    logic signed [16:0] w_ub, w_lb;
    logic signed [49:0] w_ubq, w_lbq;
    logic [47:0]        w_q;
    logic signed [49:0] w_isum;
    logic [63:0]        w_term;
    logic signed [63:0] n_acc;
    logic signed [63:0] w_tr;
    logic signed [31:0] w_ub32, w_lb32;
    logic signed [16:0] w_clamp;
    logic               w_sat;
    logic               w_slot;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;
    assign w_slot      = !r_ovalid || i_out_ready;

    // error, magnitudes and bounds
    always_comb begin
        w_err      = {r_in.setpoint[31], r_in.setpoint}
                   - {r_in.measurement[31], r_in.measurement};
        w_first    = !r_run || r_in.restart;
        w_err_neg  = -r_err;
        w_err_mag  = r_err[32] ? w_err_neg : r_err;
        w_base_neg = -r_base;
        w_base_mag = r_base[33] ? w_base_neg[32:0] : r_base[32:0];
        w_int_neg  = -r_int;
        w_int_mag  = r_int[33] ? w_int_neg[32:0] : r_int[32:0];
        w_diff_neg = -r_diff;
        w_diff_mag = r_diff[33] ? w_diff_neg[32:0] : r_diff[32:0];
        w_kp_neg   = -r_kp;
        w_kp_mag   = r_kp[23] ? w_kp_neg : r_kp;
        w_ki_neg   = -r_ki;
        w_ki_mag   = r_ki[23] ? w_ki_neg : r_ki;
        w_kd_neg   = -r_kd;
        w_kd_mag   = r_kd[23] ? w_kd_neg : r_kd;
        w_ub       = {r_hi[15], r_hi} - {r_off[15], r_off};
        w_lb       = {r_lo[15], r_lo} - {r_off[15], r_off};
        w_ubq      = {{17{w_ub[16]}}, w_ub, 16'h0000};
        w_lbq      = {{17{w_lb[16]}}, w_lb, 16'h0000};
        w_ub32     = {{15{w_ub[16]}}, w_ub};
        w_lb32     = {{15{w_lb[16]}}, w_lb};
    end

    // integral increment, truncated magnitude then signed
    always_comb begin
        w_q    = r_trap ? w_prod[64:17] : w_prod[63:16];
        w_isum = r_neg ? {{16{r_int[33]}}, r_int} - {2'b00, w_q}
                       : {{16{r_int[33]}}, r_int} + {2'b00, w_q};
    end

    // accumulate a signed term into the Q.32 sum
    always_comb begin
        w_term = (r_state == ST_DV) ? {3'b000, w_quot} : {1'b0, w_prod[62:0]};
        n_acc  = r_neg ? r_acc - $signed(w_term) : r_acc + $signed(w_term);
        w_tr   = r_acc + (r_acc[63] ? 64'sh0000_0000_FFFF_FFFF : 64'sh0);
    end

    // result clamp
    always_comb begin
        if (r_res > w_ub32) begin
            w_clamp = w_ub;
            w_sat   = 1'b1;
        end else if (r_res < w_lb32) begin
            w_clamp = w_lb;
            w_sat   = 1'b1;
        end else begin
            w_clamp = r_res[16:0];
            w_sat   = 1'b0;
        end
    end

    // multiplier and divider launch
    always_comb begin
        w_mul_a     = '0;
        w_mul_b     = '0;
        w_mul_start = 1'b0;
        w_div_start = (r_state == ST_MD) && w_mul_done && (r_in.time_delta != '0);
        unique case (r_state)
            ST_MIGO: begin
                w_mul_start = 1'b1;
                w_mul_a     = w_base_mag;
                w_mul_b     = r_in.time_delta;
            end
            ST_INT: begin
                w_mul_start = 1'b1;
                w_mul_a     = w_err_mag;
                w_mul_b     = {8'h00, w_kp_mag};
            end
            ST_MP: begin
                w_mul_start = w_mul_done;
                w_mul_a     = w_int_mag;
                w_mul_b     = {8'h00, w_ki_mag};
            end
            ST_MK: begin
                w_mul_start = w_mul_done;
                w_mul_a     = w_diff_mag;
                w_mul_b     = {8'h00, w_kd_mag};
            end
            default: begin
                w_mul_start = 1'b0;
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp   <= '0;
            r_ki   <= '0;
            r_kd   <= '0;
            r_lo   <= '0;
            r_hi   <= 16'sd32767;
            r_off  <= '0;
            r_trap <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_KP:    r_kp   <= i_cfg_data;
                CFG_KI:    r_ki   <= i_cfg_data;
                CFG_KD:    r_kd   <= i_cfg_data;
                CFG_LOWER: r_lo   <= i_cfg_data[15:0];
                CFG_UPPER: r_hi   <= i_cfg_data[15:0];
                CFG_OFFS:  r_off  <= i_cfg_data[15:0];
                CFG_TRAP:  r_trap <= i_cfg_data[0];
                default:   r_trap <= r_trap;
            endcase
        end
    end

    // sequencer and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_run    <= 1'b0;
            r_prev   <= '0;
            r_int    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == ST_CLP && w_slot) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) r_state <= ST_PREP;
                end
                ST_PREP: begin
                    r_run   <= 1'b1;
                    r_prev  <= w_err;
                    if (w_first) r_int <= '0;
                    r_state <= ST_BASE;
                end
                ST_BASE: r_state <= ST_MIGO;
                ST_MIGO: r_state <= ST_MI;
                ST_MI: begin
                    if (w_mul_done) r_state <= ST_INT;
                end
                ST_INT: begin
                    // hold the integral within the bounds, upper test first
                    if (w_isum > w_ubq) begin
                        r_int <= w_ubq[33:0];
                    end else if (w_isum < w_lbq) begin
                        r_int <= w_lbq[33:0];
                    end else begin
                        r_int <= w_isum[33:0];
                    end
                    r_state <= ST_MP;
                end
                ST_MP: begin
                    if (w_mul_done) r_state <= ST_MK;
                end
                ST_MK: begin
                    if (w_mul_done) r_state <= ST_MD;
                end
                ST_MD: begin
                    if (w_mul_done) begin
                        r_state <= (r_in.time_delta != '0) ? ST_DV : ST_FIN;
                    end
                end
                ST_DV: begin
                    if (w_div_done) r_state <= ST_FIN;
                end
                ST_FIN: r_state <= ST_CLP;
                ST_CLP: begin
                    if (w_slot) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in_valid) begin
            r_in <= i_in;
        end
        if (r_state == ST_PREP) begin
            r_err <= w_err;
            r_old <= w_first ? w_err : r_prev;
        end
        if (r_state == ST_BASE) begin
            r_base <= r_trap ? {r_err[32], r_err} + {r_old[32], r_old}
                             : {r_err[32], r_err};
            r_diff <= {r_err[32], r_err} - {r_old[32], r_old};
        end
        unique case (r_state)
            ST_MIGO: r_neg <= r_base[33];
            ST_INT: begin
                r_neg <= r_err[32] ^ r_kp[23];
                r_acc <= '0;
            end
            ST_MP: begin
                if (w_mul_done) begin
                    r_acc <= n_acc;
                    r_neg <= r_int[33] ^ r_ki[23];
                end
            end
            ST_MK: begin
                if (w_mul_done) begin
                    r_acc <= n_acc;
                    r_neg <= r_diff[33] ^ r_kd[23];
                end
            end
            ST_DV: begin
                if (w_div_done) r_acc <= n_acc;
            end
            ST_FIN: r_res <= w_tr[63:32];
            ST_CLP: begin
                if (w_slot) begin
                    r_out.drive     <= w_clamp + {r_off[15], r_off};
                    r_out.saturated <= w_sat;
                end
            end
            default: r_neg <= r_neg;
        endcase
    end

    pid_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    pid_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_prod[DIV_NW-1:0]),
        .i_den   (r_in.time_delta),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

endmodule

@@ hdl/pid_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_chk
// Port-level checks for the PID step block, bound to the top level.
// ----------------------------------------------------------------------------
module pid_chk (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  pid_pkg::t_pid_out    i_out
);
    import pid_pkg::*;

    // hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out))
        else $error("result word changed while stalled");

    // drop input ready once a word is taken
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second word taken while busy");

    // no result can follow an accepted word in the next cycle
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid))
        else $error("result appeared too early");

    // drop output valid in reset
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind pid_step_clamped pid_chk u_pid_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out       (o_out)
);

@@ sim/tb_pid_step_clamped.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pid_step_clamped
// Self-checking bench for the PID step block: a directed table, then random
// phases under several register settings, with random idling on both sides
// and one long output hold-off. Each result word is compared with a local
// fixed-point prediction of the control step.
// ----------------------------------------------------------------------------
module tb_pid_step_clamped;
    import pid_pkg::*;

    localparam int LATENCY   = 260;
    localparam int CYCLE_CAP = 2_000_000;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_pid_in i_in;
    logic o_out_valid;
    logic i_out_ready;
    t_pid_out o_out;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [CFG_IW-1:0] i_cfg_index;
    logic [CFG_DW-1:0] i_cfg_data;

    pid_step_clamped dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // local copy of registers and control state
    longint kp, ki, kd, lo_lim, hi_lim, offs;
    bit     trap;
    bit     running;
    longint prev_err, integ;

    t_pid_out drive_q[$];
    int       errors;
    int       words_out;
    int       words_in;
    longint   cycles;
    bit       hold_long;

    // directed table: expected word typed in only where obvious
    typedef struct {
        t_pid_in  word;
        bit       known;
        t_pid_out exp;
    } t_row;
    t_row rows[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // cycle counter and timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    task automatic report(input string what, input t_pid_out got, input t_pid_out exp);
        errors++;
        $display("mismatch %s word %0d: got drive %0d sat %0b, expected drive %0d sat %0b",
                 what, words_out, got.drive, got.saturated, exp.drive, exp.saturated);
    endtask

    function automatic longint sx(input longint v, input int w);
        longint s;
        s = longint'(1) <<< (w - 1);
        v = v & ((longint'(1) <<< w) - 1);
        return (v ^ s) - s;
    endfunction

    function automatic longint absv(input longint x);
        return x < 0 ? -x : x;
    endfunction

    // predict one control step and advance local state
    function automatic t_pid_out pid_predict(input t_pid_in w);
        longint err, old, lb, ub, base, p, i, d, sum, res;
        longint unsigned m, q, td, n, qi, dm;
        t_pid_out o;
        bit sat;
        err = longint'(w.setpoint) - longint'(w.measurement);
        td  = longint'(w.time_delta);
        lb  = lo_lim - offs;
        ub  = hi_lim - offs;
        sat = 1'b0;
        if (!running || w.restart) begin
            running = 1'b1;
            old     = err;
            integ   = 0;
        end else begin
            old = prev_err;
        end
        prev_err = err;
        base = trap ? err + old : err;
        m = absv(base);
        q = m * (td >> 16) + ((m * (td & 64'hFFFF)) >> 16);
        if (trap) q = q >> 1;
        integ += (base < 0) ? -longint'(q) : longint'(q);
        if (integ > ub * 65536) integ = ub * 65536;
        else if (integ < lb * 65536) integ = lb * 65536;
        p = err * kp;
        i = integ * ki;
        d = 0;
        if (td != 0) begin
            n  = absv((err - old) * kd);
            qi = n / td;
            if (qi >= (64'd1 << 44)) dm = 64'd1 << 60;
            else dm = (qi << 16) + (((n % td) << 16) / td);
            d = ((err - old) * kd < 0) ? -longint'(dm) : longint'(dm);
        end
        sum = p + i + d;
        res = longint'(longint'(absv(sum)) >>> 32);
        if (sum < 0) res = -res;
        if (res > ub) begin
            res = ub; sat = 1'b1;
        end else if (res < lb) begin
            res = lb; sat = 1'b1;
        end
        res += offs;
        o.drive     = res[16:0];
        o.saturated = sat;
        return o;
    endfunction

    // write one register while idle, mirror it locally
    task automatic cfg_write(input logic [CFG_IW-1:0] idx, input longint val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[CFG_DW-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_KP:    kp = sx(val, 24);
            CFG_KI:    ki = sx(val, 24);
            CFG_KD:    kd = sx(val, 24);
            CFG_LOWER: lo_lim = sx(val, 16);
            CFG_UPPER: hi_lim = sx(val, 16);
            CFG_OFFS:  offs = sx(val, 16);
            CFG_TRAP:  trap = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_all(input longint p, input longint i, input longint d, input longint lo,
                           input longint hi, input longint of, input longint tr);
        cfg_write(CFG_KP, p);
        cfg_write(CFG_KI, i);
        cfg_write(CFG_KD, d);
        cfg_write(CFG_LOWER, lo);
        cfg_write(CFG_UPPER, hi);
        cfg_write(CFG_OFFS, of);
        cfg_write(CFG_TRAP, tr);
    endtask

    // offer one word after a random gap; hold until accepted
    task automatic send_word(input t_pid_in w, input bit known, input t_pid_out exp);
        int gap;
        t_pid_out pr;
        gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) gap = 0;
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in       <= w;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pr = pid_predict(w);
        if (known && pr !== exp) report("table", pr, exp);
        drive_q.push_back(pr);
        words_in++;
    endtask

    // drop input valid, then wait for every result word
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (drive_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    function automatic t_pid_in rand_word(input int kind);
        t_pid_in w;
        w.setpoint    = $urandom;
        w.measurement = $urandom;
        w.time_delta  = $urandom;
        w.restart     = ($urandom_range(0, 15) == 0);
        case (kind)
            0: begin
                // realistic loop: modest errors, small time steps
                w.setpoint    = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
                w.measurement = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
                w.time_delta  = $urandom_range(0, 32'h0002_0000);
            end
            1: w.time_delta = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(1, 255);
            default: ;
        endcase
        return w;
    endfunction

    // output side: random ready, one long hold-off on request
    initial begin
        int stall;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_long) begin
                i_out_ready <= 1'b0;
                repeat (2000) @(negedge i_clk);
                hold_long = 1'b0;
            end
            stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 7);
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
                @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    // compare each accepted result word with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (drive_q.size() == 0) begin
                report("unexpected", o_out, '0);
            end else begin
                t_pid_out e;
                e = drive_q.pop_front();
                if (o_out.drive !== e.drive) report("drive", o_out, e);
                else if (o_out.saturated !== e.saturated) report("saturated", o_out, e);
            end
            words_out++;
        end
    end

    function automatic t_row mk(input longint sp, input longint ms, input longint td,
                                input bit rs, input bit known, input longint dr,
                                input bit st);
        t_row r;
        r.word.setpoint    = sp[31:0];
        r.word.measurement = ms[31:0];
        r.word.time_delta  = td[31:0];
        r.word.restart     = rs;
        r.known            = known;
        r.exp.drive        = dr[16:0];
        r.exp.saturated    = st;
        return r;
    endfunction

    initial begin
        t_pid_in w;
        int phase;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_KP;
        i_cfg_data = '0;
        hold_long = 1'b0;
        errors = 0;
        words_in = 0;
        words_out = 0;
        cycles = 0;
        kp = 0; ki = 0; kd = 0; lo_lim = 0; hi_lim = 32767; offs = 0; trap = 0;
        running = 0; prev_err = 0; integ = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset gains are zero: drive sits at zero, unsaturated
        rows.push_back(mk(32'sh7FFF_FFFF, -32'sh8000_0000, 32'hFFFF_FFFF, 0, 1, 0, 0));
        rows.push_back(mk(-32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, 1, 0, 0));
        rows.push_back(mk(0, 0, 0, 1, 1, 0, 0));
        foreach (rows[k]) send_word(rows[k].word, rows[k].known, rows[k].exp);
        drain();

        // extreme gains, wide limits, trapezoid on
        set_all(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, -32768, 32767, 0, 1);
        rows.delete();
        rows.push_back(mk(32'sh7FFF_FFFF, -32'sh8000_0000, 32'h0001_0000, 1, 1, 32767, 1));
        rows.push_back(mk(-32'sh8000_0000, 32'sh7FFF_FFFF, 1, 0, 1, -32768, 1));
        rows.push_back(mk(32'sh0001_0000, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(32'sh0001_0000, 0, 32'hFFFF_FFFF, 0, 0, 0, 0));
        rows.push_back(mk(-32'sh0001_0000, 32'sh0003_0000, 32'h0000_8000, 0, 0, 0, 0));
        rows.push_back(mk(5, 5, 32'h0001_0000, 1, 0, 0, 0));
        foreach (rows[k]) send_word(rows[k].word, rows[k].known, rows[k].exp);
        drain();

        // crossed limits with offset: result lands on a bound
        set_all(-24'sh800000, -24'sh800000, -24'sh800000, 100, -100, 32767, 0);
        rows.delete();
        rows.push_back(mk(32'sh0100_0000, 0, 32'h0001_0000, 1, 0, 0, 0));
        rows.push_back(mk(0, 32'sh0100_0000, 32'h0000_0001, 0, 0, 0, 0));
        rows.push_back(mk(0, 0, 0, 0, 0, 0, 0));
        foreach (rows[k]) send_word(rows[k].word, rows[k].known, rows[k].exp);
        drain();

        // exact bound: unity gain, error of exactly 10, upper limit 10
        set_all(24'h010000, 0, 0, -10, 10, 0, 0);
        rows.delete();
        rows.push_back(mk(32'sh000A_0000, 0, 0, 1, 1, 10, 0));
        rows.push_back(mk(32'sh000B_0000, 0, 0, 0, 1, 10, 1));
        rows.push_back(mk(-32'sh000A_0000, 0, 0, 0, 1, -10, 0));
        foreach (rows[k]) send_word(rows[k].word, rows[k].known, rows[k].exp);
        drain();

        // random phases under fresh settings
        for (phase = 0; phase < 8; phase++) begin
            if (phase == 7) set_all(0, 0, 0, 32767, -32768, -32768, 1);
            else if (phase == 6) set_all(24'h800000, 24'h7FFFFF, 24'h800000, -32768, 32767, 32767, 0);
            else set_all($urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 12),
                         $urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 12),
                         $urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 12),
                         -$urandom_range(0, 32768), $urandom_range(0, 32767),
                         $signed(16'($urandom)) >>> $urandom_range(0, 15),
                         $urandom_range(0, 1));
            if (phase == 2) hold_long = 1'b1;
            repeat (115) begin
                w = rand_word($urandom_range(0, 3) == 0 ? 2 : $urandom_range(0, 1));
                send_word(w, 1'b0, '0);
            end
            drain();
        end

        $display("sent %0d input words and checked %0d result words over twelve register settings",
                 words_in, words_out);
        $display("covered gain and limit extremes, crossed limits, restarts and zero time");
        if (errors == 0 && drive_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches, %0d predictions left", errors, drive_q.size());
            $display("status: fail");
        end
        $finish;
    end
endmodule

@@ files.f @@
hdl/pid_pkg.sv
hdl/pid_mul.sv
hdl/pid_div.sv
hdl/pid_step_clamped.sv
hdl/pid_chk.sv
sim/tb_pid_step_clamped.sv
